/* sv/rnc_pkg.sv */
// Shared types, codes and lookup functions for the Roman numeral converter.
// No dependencies; imported by roman_numeral_converter.
`default_nettype none
package rnc_pkg;

  // result kinds carried in out_tuser
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // input command carried in in_tuser
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [11:0] MAX_NUMBER = 12'd3999;
  localparam logic [3:0]  MAX_LEN    = 4'd15;

  // symbol roles inside a digit pattern
  localparam logic [1:0] ROLE_UNIT = 2'd0;
  localparam logic [1:0] ROLE_FIVE = 2'd1;
  localparam logic [1:0] ROLE_TEN  = 2'd2;

  // multiples added to the running value while decoding
  localparam logic [1:0] ADD_ONE   = 2'd0;
  localparam logic [1:0] ADD_THREE = 2'd1;
  localparam logic [1:0] ADD_FIVE  = 2'd2;
  localparam logic [1:0] ADD_EIGHT = 2'd3;

  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_M = 8'h4D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG,
    S_ENC_DIV,
    S_ENC_EMIT,
    S_DEC_STEP,
    S_DEC_RES
  } state_t;

  function automatic logic [11:0] place_weight(input logic [1:0] place);
    logic [11:0] w;
    unique case (place)
      2'd0:    w = 12'd1000;
      2'd1:    w = 12'd100;
      2'd2:    w = 12'd10;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  function automatic logic [11:0] dec_addend(input logic [1:0] place, input logic [1:0] sel);
    logic [14:0] w;
    logic [14:0] a;
    w = {3'd0, place_weight(place)};
    unique case (sel)
      ADD_ONE:   a = w;
      ADD_THREE: a = (w << 1) + w;
      ADD_FIVE:  a = (w << 2) + w;
      default:   a = w << 3;
    endcase
    return a[11:0];
  endfunction

  // characters in the pattern of a decimal digit
  function automatic logic [2:0] pattern_len(input logic [3:0] digit);
    logic [2:0] n;
    unique case (digit)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] pattern_role(input logic [3:0] digit, input logic [1:0] pos);
    logic [1:0] r;
    unique case (digit)
      4'd4:                r = (pos == 2'd0) ? ROLE_UNIT : ROLE_FIVE;
      4'd5:                r = ROLE_FIVE;
      4'd6, 4'd7, 4'd8:    r = (pos == 2'd0) ? ROLE_FIVE : ROLE_UNIT;
      4'd9:                r = (pos == 2'd0) ? ROLE_UNIT : ROLE_TEN;
      default:             r = ROLE_UNIT;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] place_symbol(input logic [1:0] place, input logic [1:0] role);
    logic [7:0] c;
    unique case (place)
      2'd0:    c = CH_M;
      2'd1:    c = (role == ROLE_UNIT) ? CH_C : ((role == ROLE_FIVE) ? CH_D : CH_M);
      2'd2:    c = (role == ROLE_UNIT) ? CH_X : ((role == ROLE_FIVE) ? CH_L : CH_C);
      default: c = (role == ROLE_UNIT) ? CH_I : ((role == ROLE_FIVE) ? CH_V : CH_X);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/roman_numeral_converter.sv */
// Roman numeral converter top level: sequencer around one shared 12-bit adder.
// Depends on rnc_pkg for codes, state type and symbol tables.
//
// Usage:
//   in_*  : one item per transfer. in_tuser selects encode (0) or decode (1).
//           Encode takes the number in in_tdata[11:0]; decode takes one ASCII
//           character in in_tdata[19:12], with in_tlast on the final one.
//   out_* : results. out_tuser gives the kind (character, value, empty, error),
//           out_tlast marks the last result caused by an input item.
//   Encode splits the number by repeated subtraction of 1000, 100, 10 and 1
//   in the shared adder (one step a cycle, up to 30 steps plus 4 place
//   changes), then sends one character a cycle while the output register is
//   free, skipping zero places; out of range and zero go through the flag
//   state, which loads one result once the output register is free.
//   A decode character passes the step state, and the result state when it
//   closes the string; the running value update goes through the same adder.
//   in_tready is high only while the sequencer is idle; one output register
//   holds a result while the receiver stalls and the sequencer waits on it.
//   Reset (rst_n low, synchronous) empties the output register and clears
//   the decode state; a partly received string is dropped.
//   Encode items may fall between the characters of a decode string.
`default_nettype none
module roman_numeral_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [11:0] number_in, [19:12] char_in, [23:20] zero
  input  wire logic        in_tuser,   // [0] command
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] char_out, [19:8] value_out, [23:20] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last_out
);
  import rnc_pkg::*;

  state_t state_r, state_nxt;

  // item latches
  logic [7:0]  char_r, char_nxt;
  logic        eos_r, eos_nxt;
  logic [1:0]  flag_kind_r, flag_kind_nxt;

  // encode state
  logic [11:0] rem_r, rem_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic [1:0]  place_r, place_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  digit_store [4];
  logic        store_we;

  // decode state
  logic [11:0] rv_r, rv_nxt;
  logic [1:0]  dplace_r, dplace_nxt;
  logic [2:0]  pphase_r, pphase_nxt;
  logic [3:0]  ccount_r, ccount_nxt;
  logic        bad_r, bad_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [7:0]  ochar_r, ochar_nxt;
  logic [11:0] oval_r, oval_nxt;
  logic        olast_r, olast_nxt;

  // shared adder / subtractor
  logic [11:0] alu_a, alu_b;
  logic        alu_sub;
  logic [12:0] alu_res;
  logic        alu_ge;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_ge  = ~alu_res[12];

  logic slot_free;
  assign slot_free = !ov_r || out_tready;

  // encode emit helpers
  logic [3:0] cur_digit;
  logic [2:0] cur_len;
  logic       tail_zero;
  logic       pat_end;

  assign cur_digit = digit_store[place_r];
  assign cur_len   = pattern_len(cur_digit);
  assign pat_end   = ({1'b0, phase_r} == cur_len - 3'd1);

  always_comb begin
    tail_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (i > int'(place_r) && digit_store[i] != 4'd0) tail_zero = 1'b0;
    end
  end

  // symbol classification for decode
  logic       cls_ok;
  logic [1:0] cls_place;
  logic       cls_five;

  always_comb begin
    cls_ok    = 1'b1;
    cls_place = 2'd0;
    cls_five  = 1'b0;
    case (char_r)
      CH_M: cls_place = 2'd0;
      CH_C: cls_place = 2'd1;
      CH_D: begin cls_place = 2'd1; cls_five = 1'b1; end
      CH_X: cls_place = 2'd2;
      CH_L: begin cls_place = 2'd2; cls_five = 1'b1; end
      CH_I: cls_place = 2'd3;
      CH_V: begin cls_place = 2'd3; cls_five = 1'b1; end
      default: cls_ok = 1'b0;
    endcase
  end

  // decode step decision
  logic       dec_add;
  logic [1:0] dec_sel;
  logic [1:0] dec_place;

  always_comb begin
    bad_nxt    = bad_r;
    ccount_nxt = ccount_r;
    dplace_nxt = dplace_r;
    pphase_nxt = pphase_r;
    dec_add    = 1'b0;
    dec_sel    = ADD_ONE;
    dec_place  = dplace_r;
    if (ccount_r >= MAX_LEN) begin
      bad_nxt = 1'b1;
    end else begin
      ccount_nxt = ccount_r + 4'd1;
      if (!bad_r) begin
        if (!cls_ok) begin
          bad_nxt = 1'b1;
        end else if (ccount_r == 4'd0 || cls_place > dplace_r) begin
          // open a new, lower place
          dplace_nxt = cls_place;
          pphase_nxt = cls_five ? 3'd4 : 3'd1;
          dec_add    = 1'b1;
          dec_sel    = cls_five ? ADD_FIVE : ADD_ONE;
          dec_place  = cls_place;
        end else if (cls_place == dplace_r) begin
          if (!cls_five) begin
            if (pphase_r == 3'd1 || pphase_r == 3'd2 || pphase_r == 3'd4 ||
                pphase_r == 3'd5 || pphase_r == 3'd6) begin
              pphase_nxt = pphase_r + 3'd1;
              dec_add    = 1'b1;
            end else begin
              bad_nxt = 1'b1;
            end
          end else if (pphase_r == 3'd1) begin
            // unit then five: four
            pphase_nxt = 3'd0;
            dec_add    = 1'b1;
            dec_sel    = ADD_THREE;
          end else begin
            bad_nxt = 1'b1;
          end
        end else if (cls_place + 2'd1 == dplace_r && !cls_five && pphase_r == 3'd1) begin
          // unit then ten: nine
          pphase_nxt = 3'd0;
          dec_add    = 1'b1;
          dec_sel    = ADD_EIGHT;
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    char_nxt      = char_r;
    eos_nxt       = eos_r;
    flag_kind_nxt = flag_kind_r;
    rem_nxt       = rem_r;
    digit_nxt     = digit_r;
    place_nxt     = place_r;
    phase_nxt     = phase_r;
    store_we      = 1'b0;
    rv_nxt        = rv_r;
    ov_nxt        = ov_r && !out_tready;
    okind_nxt     = okind_r;
    ochar_nxt     = ochar_r;
    oval_nxt      = oval_r;
    olast_nxt     = olast_r;
    in_tready     = 1'b0;
    alu_a         = rem_r;
    alu_b         = place_weight(place_r);
    alu_sub       = 1'b1;

    // decode registers hold unless the decode step or result commits them
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == CMD_DECODE) begin
            char_nxt  = in_tdata[19:12];
            eos_nxt   = in_tlast;
            state_nxt = S_DEC_STEP;
          end else if (in_tdata[11:0] > MAX_NUMBER) begin
            flag_kind_nxt = KIND_ERROR;
            state_nxt     = S_FLAG;
          end else if (in_tdata[11:0] == 12'd0) begin
            flag_kind_nxt = KIND_EMPTY;
            state_nxt     = S_FLAG;
          end else begin
            rem_nxt   = in_tdata[11:0];
            digit_nxt = 4'd0;
            place_nxt = 2'd0;
            state_nxt = S_ENC_DIV;
          end
        end
      end
      S_FLAG: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = flag_kind_r;
          ochar_nxt = 8'd0;
          oval_nxt  = 12'd0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ENC_DIV: begin
        if (alu_ge) begin
          rem_nxt   = alu_res[11:0];
          digit_nxt = digit_r + 4'd1;
        end else begin
          store_we  = 1'b1;
          digit_nxt = 4'd0;
          place_nxt = place_r + 2'd1;
          phase_nxt = 2'd0;
          if (place_r == 2'd3) state_nxt = S_ENC_EMIT;
        end
      end
      S_ENC_EMIT: begin
        if (cur_len == 3'd0) begin
          // zero digit: skip the place
          place_nxt = place_r + 2'd1;
        end else if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_CHAR;
          ochar_nxt = place_symbol(place_r, pattern_role(cur_digit, phase_r));
          oval_nxt  = 12'd0;
          olast_nxt = pat_end && tail_zero;
          if (pat_end) begin
            phase_nxt = 2'd0;
            place_nxt = place_r + 2'd1;
            if (tail_zero) state_nxt = S_IDLE;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      S_DEC_STEP: begin
        alu_a   = rv_r;
        alu_b   = dec_addend(dec_place, dec_sel);
        alu_sub = 1'b0;
        if (dec_add) rv_nxt = alu_res[11:0];
        state_nxt = eos_r ? S_DEC_RES : S_IDLE;
      end
      S_DEC_RES: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ochar_nxt = 8'd0;
          olast_nxt = 1'b1;
          if (bad_r || rv_r == 12'd0 || rv_r > MAX_NUMBER) begin
            okind_nxt = KIND_ERROR;
            oval_nxt  = 12'd0;
          end else begin
            okind_nxt = KIND_VALUE;
            oval_nxt  = rv_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      rv_r     <= 12'd0;
      dplace_r <= 2'd0;
      pphase_r <= 3'd0;
      ccount_r <= 4'd0;
      bad_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (state_r == S_DEC_STEP) begin
        rv_r     <= rv_nxt;
        dplace_r <= dplace_nxt;
        pphase_r <= pphase_nxt;
        ccount_r <= ccount_nxt;
        bad_r    <= bad_nxt;
      end else if (state_r == S_DEC_RES && slot_free) begin
        // string closed: return the decoder to its reset state
        rv_r     <= 12'd0;
        dplace_r <= 2'd0;
        pphase_r <= 3'd0;
        ccount_r <= 4'd0;
        bad_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    eos_r       <= eos_nxt;
    flag_kind_r <= flag_kind_nxt;
    rem_r       <= rem_nxt;
    digit_r     <= digit_nxt;
    place_r     <= place_nxt;
    phase_r     <= phase_nxt;
    okind_r     <= okind_nxt;
    ochar_r     <= ochar_nxt;
    oval_r      <= oval_nxt;
    olast_r     <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) digit_store[place_r] <= digit_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oval_r, ochar_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

/* tb/sv/roman_numeral_converter_tb.sv */
// Self-checking testbench for roman_numeral_converter: directed and random
// encode and decode traffic, checked against an in-bench conversion model.
// Depends on rnc_pkg (sv/rnc_pkg.sv) and the converter RTL.
module roman_numeral_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rnc_pkg::*;

  localparam logic [7:0] LOWER_I     = 8'h69;
  localparam int         DRAIN_HOLD  = 64;
  localparam int         PHASE_ITEMS = 110;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [11:0] value;
    logic        last;
  } conv_result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [11:0] number_in, [19:12] char_in, [23:20] zero
  logic        in_tuser   = CMD_ENCODE;  // [0] command
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] char_out, [19:8] value_out, [23:20] zero
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;

  // model of the decode string in progress
  logic [11:0] dec_total;
  logic [1:0]  dec_place;
  logic [2:0]  dec_phase;
  logic [3:0]  dec_len;
  logic        dec_bad;

  conv_result_t pending_results[$];
  int           fail_count     = 0;
  int           items_sent     = 0;
  int           send_gap_pct   = 0;
  int           recv_stall_pct = 0;

  logic [7:0] roman_syms[7] = '{CH_I, CH_V, CH_X, CH_L, CH_C, CH_D, CH_M};

  roman_numeral_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [11:0] decade_weight(input logic [1:0] place);
    case (place)
      2'd0:    return 12'd1000;
      2'd1:    return 12'd100;
      2'd2:    return 12'd10;
      default: return 12'd1;
    endcase
  endfunction

  // canonical numeral for 1..3999, most significant place first
  function automatic void build_numeral(input int unsigned n, ref logic [7:0] chars[$]);
    int unsigned digit;
    logic [7:0]  unit_c;
    logic [7:0]  five_c;
    logic [7:0]  ten_c;
    chars.delete();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          digit = n / 1000; unit_c = CH_M; five_c = CH_M; ten_c = CH_M;
        end
        1: begin
          digit = (n / 100) % 10; unit_c = CH_C; five_c = CH_D; ten_c = CH_M;
        end
        2: begin
          digit = (n / 10) % 10; unit_c = CH_X; five_c = CH_L; ten_c = CH_C;
        end
        default: begin
          digit = n % 10; unit_c = CH_I; five_c = CH_V; ten_c = CH_X;
        end
      endcase
      case (digit)
        1, 2, 3: for (int k = 0; k < digit; k++) chars.insert(chars.size(), unit_c);
        4: begin
          chars.insert(chars.size(), unit_c); chars.insert(chars.size(), five_c);
        end
        5: chars.insert(chars.size(), five_c);
        6, 7, 8: begin
          chars.insert(chars.size(), five_c);
          for (int k = 5; k < digit; k++) chars.insert(chars.size(), unit_c);
        end
        9: begin
          chars.insert(chars.size(), unit_c); chars.insert(chars.size(), ten_c);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] ch, logic [11:0] value,
                                      logic last);
    conv_result_t r;
    r = '{kind, ch, value, last};
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void clear_string_state();
    dec_total = '0;
    dec_place = '0;
    dec_phase = '0;
    dec_len   = '0;
    dec_bad   = 1'b0;
  endfunction

  // advance the decode state by one character
  function automatic void take_numeral_char(logic [7:0] c);
    logic       known;
    logic       five;
    logic [1:0] q;
    logic       first;
    known = 1'b1;
    five  = 1'b0;
    q     = 2'd0;
    first = (dec_len == 0);
    if (dec_len == MAX_LEN) begin
      dec_bad = 1'b1;
      return;
    end
    dec_len++;
    if (dec_bad) return;
    case (c)
      CH_M:    q = 2'd0;
      CH_C:    q = 2'd1;
      CH_D:    begin q = 2'd1; five = 1'b1; end
      CH_X:    q = 2'd2;
      CH_L:    begin q = 2'd2; five = 1'b1; end
      CH_I:    q = 2'd3;
      CH_V:    begin q = 2'd3; five = 1'b1; end
      default: known = 1'b0;
    endcase
    if (!known) begin
      dec_bad = 1'b1;
    end else if (first || q > dec_place) begin
      dec_place = q;
      dec_phase = five ? 3'd4 : 3'd1;
      dec_total = dec_total + decade_weight(q) * (five ? 12'd5 : 12'd1);
    end else if (q == dec_place) begin
      if (!five) begin
        if (dec_phase inside {3'd1, 3'd2, 3'd4, 3'd5, 3'd6}) begin
          dec_phase++;
          dec_total = dec_total + decade_weight(q);
        end else begin
          dec_bad = 1'b1;
        end
      end else if (dec_phase == 3'd1) begin
        dec_total = dec_total + 12'd3 * decade_weight(q);
        dec_phase = 3'd0;
      end else begin
        dec_bad = 1'b1;
      end
    end else if (int'(q) + 1 == int'(dec_place) && !five && dec_phase == 3'd1) begin
      dec_total = dec_total + 12'd8 * decade_weight(dec_place);
      dec_phase = 3'd0;
    end else begin
      dec_bad = 1'b1;
    end
  endfunction

  function automatic void predict_conversion(logic cmd, logic [11:0] number, logic [7:0] ch,
                                             logic eos);
    logic [7:0] chars[$];
    if (cmd == CMD_ENCODE) begin
      if (number > MAX_NUMBER) begin
        push_result(KIND_ERROR, 8'd0, 12'd0, 1'b1);
      end else if (number == 0) begin
        push_result(KIND_EMPTY, 8'd0, 12'd0, 1'b1);
      end else begin
        build_numeral(number, chars);
        foreach (chars[i]) push_result(KIND_CHAR, chars[i], 12'd0, i == chars.size() - 1);
      end
    end else begin
      take_numeral_char(ch);
      if (eos) begin
        if (dec_bad || dec_total == 0 || dec_total > MAX_NUMBER)
          push_result(KIND_ERROR, 8'd0, 12'd0, 1'b1);
        else
          push_result(KIND_VALUE, 8'd0, dec_total, 1'b1);
        clear_string_state();
      end
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // receiver: stall at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    conv_result_t got;
    conv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[19:8], out_tlast};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: kind %0d char %h value %0d last %0b",
                               got.kind, got.ch, got.value, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.value !== want.value ||
            got.last !== want.last)
          note_failure($sformatf({"result mismatch: expected kind %0d char %h value %0d ",
                                  "last %0b, got kind %0d char %h value %0d last %0b"},
                                 want.kind, want.ch, want.value, want.last,
                                 got.kind, got.ch, got.value, got.last));
      end
    end
  end

  // one transfer on the input side, predicted once accepted
  task automatic send_item(logic cmd, logic [11:0] number, logic [7:0] ch, logic eos);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {4'd0, ch, number};
    in_tlast  = eos;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    predict_conversion(cmd, number, ch, eos);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // one decode string; an encode item is slipped in before position enc_pos
  task automatic send_numeral(logic [7:0] chars[$], int enc_pos, logic [11:0] enc_num);
    foreach (chars[i]) begin
      if (i == enc_pos) send_item(CMD_ENCODE, enc_num, 8'd0, 1'b0);
      send_item(CMD_DECODE, $urandom_range(4095), chars[i], i == chars.size() - 1);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_HOLD) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_number();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 12'd0;
    if (r < 16) return 12'($urandom_range(4095, 4000));
    return 12'($urandom_range(3999, 1));
  endfunction

  task automatic test_encode_extremes();
    logic [11:0] nums[$];
    nums = '{12'd0, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'hAAA};
    foreach (nums[i]) send_item(CMD_ENCODE, nums[i], 8'd0, 1'b0);
  endtask

  task automatic test_decode_cases();
    logic [7:0] chars[$];
    // encode in the middle of a string leaves the string intact
    chars = '{CH_X, CH_C};
    send_numeral(chars, 1, 12'd1949);
    // lower case is foreign
    chars = '{LOWER_I};
    send_numeral(chars, -1, 12'd0);
    // sixteen characters: too long even though the start is canonical
    build_numeral(3888, chars);
    chars.insert(chars.size(), CH_I);
    send_numeral(chars, -1, 12'd0);
  endtask

  task automatic run_random_phase(int count);
    int          stop_at;
    int          r;
    int          idx;
    logic [7:0]  chars[$];
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_item(CMD_ENCODE, pick_number(), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 92) begin
        build_numeral($urandom_range(3999, 1), chars);
        if (r >= 80) begin
          idx = $urandom_range(chars.size() - 1);
          case ($urandom_range(4))
            0: chars[idx] = 8'($urandom_range(255));
            1: chars[idx] = chars[idx] | 8'h20;
            2: chars.insert(idx, chars[idx]);
            3: chars.insert(chars.size(), roman_syms[$urandom_range(6)]);
            default: while (chars.size() < 16 + $urandom_range(2)) chars.push_front(CH_M);
          endcase
        end
        send_numeral(chars, ($urandom_range(99) < 15) ? $urandom_range(chars.size() - 1) : -1,
                     pick_number());
      end else begin
        chars.delete();
        repeat ($urandom_range(4, 1))
          chars.insert(chars.size(), $urandom_range(1) ? 8'($urandom_range(255))
                                                       : roman_syms[$urandom_range(6)]);
        send_numeral(chars, -1, 12'd0);
      end
    end
  endtask

  task automatic test_random_traffic();
    send_gap_pct   = 14;
    recv_stall_pct = 54;
    run_random_phase(PHASE_ITEMS);
    // hold the sender until the output side is empty
    wait_results_drained();
    send_gap_pct   = 54;
    recv_stall_pct = 14;
    run_random_phase(PHASE_ITEMS);
    wait_results_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random_phase(PHASE_ITEMS);
  endtask

  initial begin
    clear_string_state();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_encode_extremes();
    test_decode_cases();
    test_random_traffic();
    wait_results_drained();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* roman_numeral_converter.f */
sv/rnc_pkg.sv
sv/roman_numeral_converter.sv
tb/sv/roman_numeral_converter_tb.sv
